FILE: rtl/bmdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmdf_pkg
// Types and constants shared by the 2x2 mip downsampler with fade.
// ----------------------------------------------------------------------------
package bmdf_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int IDX_W      = (COL_W > 1) ? COL_W - 1 : 1;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 13;
    localparam int CMP_W      = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
    localparam int PSUM_W     = 9;
    localparam int LINE_W     = 4 * PSUM_W;
    localparam int BSUM_W     = PSUM_W + 1;
    localparam int WT_W       = 9;
    localparam int NUM_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_COLOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_RGB_EN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_ALPHA_EN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT  = 3'd5;

    localparam logic [DIM_W-1:0] DIM_RESET  = 13'd4096;
    localparam logic [WT_W-1:0]  WT_FULL    = 9'd256;

    typedef struct packed {
        logic [7:0] in_byte0;
        logic [7:0] in_byte1;
        logic [7:0] in_byte2;
        logic [7:0] in_alpha;
    } t_in_pix;

    typedef struct packed {
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_alpha;
        logic       row_end;
        logic       image_end;
    } t_out_pix;

endpackage
`default_nettype wire

FILE: rtl/bmdf_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmdf_in_if
// Source pixel channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmdf_in_if import bmdf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_in_pix data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/bmdf_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmdf_out_if
// Downsampled pixel channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmdf_out_if import bmdf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_out_pix data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/bmdf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/box_mip_downsample_fade.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_mip_downsample_fade
// Downsamples a raster image by 2x2 box filtering, with optional fade of the
// color and alpha channels toward a constant color and a 9/8 alpha boost.
// ----------------------------------------------------------------------------
// One request is accepted per cycle while the output is not stalled, set by the
// single write and single read port of the pair-sum line store.
// The result of a 2x2 block is registered in the line read and stage 1, then
// the blend products (stage 2), then the blend sum and saturation (output register).
// Reset clears the counters, the held left pixel, the pipeline and the
// registers to their defaults; the line store is not cleared.
// ----------------------------------------------------------------------------
module box_mip_downsample_fade import bmdf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bmdf_in_if.sink               i_in,
    bmdf_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [CMP_W-1:0] W_HI = CMP_W'(MAX_WIDTH & ~1);
    localparam logic [CMP_W-1:0] H_HI = CMP_W'(MAX_HEIGHT & ~1);
    localparam logic [CMP_W-1:0] DIM_LO = CMP_W'(2);

    function automatic logic [7:0] sat8(input logic [8:0] v);
        return v[8] ? 8'hff : v[7:0];
    endfunction

    // Configuration registers.
    logic [DIM_W-1:0] r_cfg_width;
    logic [DIM_W-1:0] r_cfg_height;
    logic [31:0]      r_cfg_fade;
    logic             r_cfg_rgb_en;
    logic             r_cfg_alpha_en;
    logic [WT_W-1:0]  r_cfg_wt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width    <= DIM_RESET;
            r_cfg_height   <= DIM_RESET;
            r_cfg_fade     <= '0;
            r_cfg_rgb_en   <= 1'b0;
            r_cfg_alpha_en <= 1'b0;
            r_cfg_wt       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SOURCE_WIDTH:  r_cfg_width    <= i_cfg_data[DIM_W-1:0];
                CFG_SOURCE_HEIGHT: r_cfg_height   <= i_cfg_data[DIM_W-1:0];
                CFG_FADE_COLOR:    r_cfg_fade     <= i_cfg_data[31:0];
                CFG_FADE_RGB_EN:   r_cfg_rgb_en   <= i_cfg_data[0];
                CFG_FADE_ALPHA_EN: r_cfg_alpha_en <= i_cfg_data[0];
                CFG_BLEND_WEIGHT:  r_cfg_wt       <= i_cfg_data[WT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective size and weight.
    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] height_eff;
    logic [CMP_W-1:0] width_even;
    logic [CMP_W-1:0] height_even;
    logic [WT_W-1:0]  wt_eff;

    always_comb begin
        width_even  = CMP_W'({r_cfg_width[DIM_W-1:1], 1'b0});
        height_even = CMP_W'({r_cfg_height[DIM_W-1:1], 1'b0});
        width_eff   = width_even;
        height_eff  = height_even;
        if (width_even < DIM_LO) begin
            width_eff = DIM_LO;
        end
        if (width_even > W_HI) begin
            width_eff = W_HI;
        end
        if (height_even < DIM_LO) begin
            height_eff = DIM_LO;
        end
        if (height_even > H_HI) begin
            height_eff = H_HI;
        end
        wt_eff = (r_cfg_wt > WT_FULL) ? WT_FULL : r_cfg_wt;
    end

    // Handshake chain.
    logic r_s1_v;
    logic r_s2_v;
    logic r_o_v;
    logic o_free;
    logic s2_free;
    logic s1_free;
    logic accept;

    assign o_free  = !r_o_v || o_out.ready;
    assign s2_free = !r_s2_v || o_free;
    assign s1_free = !r_s1_v || s2_free;
    assign i_in.ready = s1_free;
    assign accept  = i_in.valid && s1_free;

    // Position counters and the held left pixel.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [31:0]      r_left;
    logic             last_col;
    logic             last_row;
    logic [7:0]       px [4];
    logic [PSUM_W-1:0] ps [4];
    logic [LINE_W-1:0] ps_line;
    logic [IDX_W-1:0] line_idx;
    logic             ram_we;
    logic             ram_re;
    logic [LINE_W-1:0] ram_q;

    always_comb begin
        last_col = (CMP_W'(r_col) + CMP_W'(1)) >= width_eff;
        last_row = (CMP_W'(r_row) + CMP_W'(1)) >= height_eff;
        px[0] = i_in.data.in_byte0;
        px[1] = i_in.data.in_byte1;
        px[2] = i_in.data.in_byte2;
        px[3] = i_in.data.in_alpha;
        for (int c = 0; c < 4; c++) begin
            ps[c] = PSUM_W'(r_left[8*c +: 8]) + PSUM_W'(px[c]);
            ps_line[PSUM_W*c +: PSUM_W] = ps[c];
        end
        line_idx = IDX_W'(CMP_W'(r_col) >> 1);
        ram_we   = accept && r_col[0] && !r_row[0];
        ram_re   = accept && r_col[0] && r_row[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (accept) begin
            if (!r_col[0]) begin
                r_left <= {px[3], px[2], px[1], px[0]};
            end
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : ROW_W'(CMP_W'(r_row) + CMP_W'(1));
            end else begin
                r_col <= COL_W'(CMP_W'(r_col) + CMP_W'(1));
            end
        end
    end

    bmdf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (line_idx),
        .i_wdata (ps_line),
        .i_re    (ram_re),
        .i_raddr (line_idx),
        .o_rdata (ram_q)
    );

    // Stage 1: current pair sums wait for the line read.
    logic [PSUM_W-1:0] r_s1_ps [4];
    logic              r_s1_rend;
    logic              r_s1_iend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_free) begin
            r_s1_v <= ram_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && ram_re) begin
            r_s1_ps   <= ps;
            r_s1_rend <= last_col;
            r_s1_iend <= last_col && last_row;
        end
    end

    // Block sums and blend products.
    logic [BSUM_W-1:0] bsum [4];
    logic [7:0]        fade_m [4];
    logic [WT_W-1:0]   wt_c [4];
    logic [NUM_W-1:0]  pa [4];
    logic [NUM_W-1:0]  pb [4];

    always_comb begin
        fade_m[0] = r_cfg_fade[23:16];
        fade_m[1] = r_cfg_fade[15:8];
        fade_m[2] = r_cfg_fade[7:0];
        fade_m[3] = r_cfg_fade[31:24];
        for (int c = 0; c < 4; c++) begin
            bsum[c] = BSUM_W'(ram_q[PSUM_W*c +: PSUM_W]) + BSUM_W'(r_s1_ps[c]);
            if (c == 3) begin
                wt_c[c] = r_cfg_alpha_en ? wt_eff : '0;
            end else begin
                wt_c[c] = r_cfg_rgb_en ? wt_eff : '0;
            end
            pa[c] = NUM_W'(bsum[c]) * NUM_W'(WT_FULL - wt_c[c]);
            pb[c] = (NUM_W'(fade_m[c]) * NUM_W'(wt_c[c])) << 2;
        end
    end

    // Stage 2: blend products.
    logic [NUM_W-1:0] r_s2_pa [4];
    logic [NUM_W-1:0] r_s2_pb [4];
    logic             r_s2_rend;
    logic             r_s2_iend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_free) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_v) begin
            r_s2_pa   <= pa;
            r_s2_pb   <= pb;
            r_s2_rend <= r_s1_rend;
            r_s2_iend <= r_s1_iend;
        end
    end

    // Blend sum, alpha boost and saturation.
    logic [NUM_W-1:0]   num [4];
    logic [NUM_W+3:0]   alpha9;
    t_out_pix           n_o_data;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            num[c] = r_s2_pa[c] + r_s2_pb[c];
        end
        alpha9 = ((NUM_W+4)'(num[3]) << 3) + (NUM_W+4)'(num[3]);
        n_o_data.out_byte0 = sat8(9'(num[0] >> 10));
        n_o_data.out_byte1 = sat8(9'(num[1] >> 10));
        n_o_data.out_byte2 = sat8(9'(num[2] >> 10));
        n_o_data.out_alpha = sat8(9'(alpha9 >> 13));
        n_o_data.row_end   = r_s2_rend;
        n_o_data.image_end = r_s2_iend;
    end

    // Output register.
    t_out_pix r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (o_free) begin
            r_o_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && r_s2_v) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_out.valid = r_o_v;
    assign o_out.data  = r_o_data;

    // Checks.
    a_stall_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_s1_v)
        else $error("input stalled with stage 1 empty");

    a_read_odd_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_row[0] && r_col[0] && !ram_we))
        else $error("line read outside an odd row or column");

    a_read_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> r_s1_v)
        else $error("line read lost its stage 1 slot");

    a_image_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.data.image_end || o_out.data.row_end))
        else $error("image end without row end");

endmodule
`default_nettype wire
